/* design/csp_pkg.sv */
package csp_pkg;

    // Nanoseconds in one second.
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // Nanoseconds in two seconds, the upper bound for the divider correction.
    localparam logic [31:0] NS_PER_TWO_SEC = 32'd2000000000;

    // floor(2^61 / 1e9). Multiplying product bits [60:30] by this and keeping
    // bits [61:31] gives a quotient estimate that is low by at most two.
    localparam logic [31:0] RECIP = 32'd2305843009;

    // Quotient bits kept by the divider and width of the product it divides.
    localparam int QUO_W = 31;
    localparam int REM_W = 61;

    // Products at or above this limit give a quotient that no longer fits in
    // QUO_W bits; such a target always exceeds any total.
    localparam logic [71:0] SAT_LIMIT = {42'd0, NS_PER_SEC} << QUO_W;

    // One beat moving through the divider stages.
    typedef struct packed {
        logic             valid;
        logic             start;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } csp_div_t;

endpackage

/* design/catchup_send_pacer.sv */
// Channel   Direction  Fields
// s_*       in         tdata: now_ns[47:0]; tuser: start_req
// m_*       out        tdata: burst, first_seq, largest_burst; tuser: done_res
// APB       in/out     send_rate at 0x0, total_sends at 0x4
//
// One beat is accepted every clock cycle unless the output side stalls a
// full pipeline. After its beat is accepted, a result is registered in
// turn after elapsed time, the split 24x24 multiply and the product sum,
// then after each step of the division by one billion (reciprocal estimate,
// back-multiply, correction by up to two), and last in the output register
// where the run state is updated. Reset is asynchronous and clears all
// control state at once. A stall on the output side backs up only through
// full stages, so beats are still taken while the pipeline holds bubbles.
module catchup_send_pacer (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [47:0] now_ns
    input  logic        s_tuser,   // [0] start_req
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [30:0] burst, [62:31] first_seq,
                                   // [93:63] largest_burst, [95:94] zero
    output logic        m_tuser,   // [0] done_res
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register select is address bit 2: send_rate below, total_sends above.
    localparam logic REG_SEND_RATE   = 1'b0;
    localparam logic REG_TOTAL_SENDS = 1'b1;

    logic [23:0] send_rate_reg;
    logic [30:0] total_sends_reg;
    logic        cfg_write;

    logic [2:0]        scale_en;
    logic [1:0]        scale_valid;
    csp_pkg::csp_div_t scale_out;
    logic [2:0]        div_en;
    logic [1:0]        div_valid;
    csp_pkg::csp_div_t div_out;
    logic              track_en;

    logic [30:0] burst;
    logic [31:0] first_seq;
    logic [30:0] largest_burst;
    logic        done_res;

    // Configuration registers. Writes land on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_rate_reg   <= 24'd1000;
            total_sends_reg <= 31'd1000000;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SEND_RATE:   send_rate_reg   <= pwdata[23:0];
                REG_TOTAL_SENDS: total_sends_reg <= pwdata[30:0];
                default:         send_rate_reg   <= send_rate_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_TOTAL_SENDS) ? {1'b0, total_sends_reg}
                                                  : {8'd0, send_rate_reg};

    // Stall chain: a stage may load whenever it is empty or its content
    // moves on in the same cycle.
    assign div_en[2]   = !div_out.valid || track_en;
    assign div_en[1]   = !div_valid[1] || div_en[2];
    assign div_en[0]   = !div_valid[0] || div_en[1];
    assign scale_en[2] = !scale_out.valid || div_en[0];
    assign scale_en[1] = !scale_valid[1] || scale_en[2];
    assign scale_en[0] = !scale_valid[0] || scale_en[1];
    assign s_tready    = scale_en[0];

    csp_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (scale_en),
        .in_valid    (s_tvalid),
        .in_start    (s_tuser),
        .in_now      (s_tdata),
        .send_rate   (send_rate_reg),
        .stage_valid (scale_valid),
        .out_stage   (scale_out)
    );

    // Division of the scaled product by one billion.
    csp_div_stage u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (div_en),
        .in_stage    (scale_out),
        .stage_valid (div_valid),
        .out_stage   (div_out)
    );

    csp_track u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_stage      (div_out),
        .total_sends   (total_sends_reg),
        .m_tready      (m_tready),
        .en            (track_en),
        .m_tvalid      (m_tvalid),
        .burst         (burst),
        .first_seq     (first_seq),
        .largest_burst (largest_burst),
        .done_res      (done_res)
    );

    assign m_tdata = {2'b00, largest_burst, first_seq, burst};
    assign m_tuser = done_res;

`ifndef SYNTHESIS
    // The largest burst of a run includes the burst reported with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[93:63] >= m_tdata[30:0]))
        else $error("largest_burst below burst");

    // With the output register empty nothing in the pipeline can stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A result held back by the sink keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");
`endif

endmodule

/* design/csp_scale.sv */
module csp_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          en,
    input  logic                in_valid,
    input  logic                in_start,
    input  logic [47:0]         in_now,
    input  logic [23:0]         send_rate,
    output logic [1:0]          stage_valid,
    output csp_pkg::csp_div_t   out_stage
);

    logic [47:0] start_time_reg;
    logic        a_valid_reg;
    logic        a_start_reg;
    logic [47:0] a_elapsed_reg;
    logic [47:0] elapsed_next;
    logic        b_valid_reg;
    logic        b_start_reg;
    logic [47:0] b_phi_reg;
    logic [47:0] b_plo_reg;
    logic        c_valid_reg;
    logic        c_start_reg;
    logic        c_ovf_reg;
    logic [60:0] c_rem_reg;
    logic [71:0] product_next;

    // A start beat is evaluated against its own time stamp.
    assign elapsed_next = in_start ? 48'd0 : in_now - start_time_reg;
    assign product_next = {b_phi_reg, 24'd0} + {24'd0, b_plo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= 48'd0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end
        else
        begin
            if (en[0] && in_valid && in_start)
            begin
                start_time_reg <= in_now;
            end
            if (en[0])
            begin
                a_valid_reg <= in_valid;
            end
            if (en[1])
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en[2])
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_start_reg   <= in_start;
            a_elapsed_reg <= elapsed_next;
        end
        if (en[1])
        begin
            b_start_reg <= a_start_reg;
            b_phi_reg   <= {24'd0, a_elapsed_reg[47:24]} * {24'd0, send_rate};
            b_plo_reg   <= {24'd0, a_elapsed_reg[23:0]} * {24'd0, send_rate};
        end
        if (en[2])
        begin
            c_start_reg <= b_start_reg;
            c_ovf_reg   <= (product_next >= csp_pkg::SAT_LIMIT);
            c_rem_reg   <= product_next[60:0];
        end
    end

    assign stage_valid     = {b_valid_reg, a_valid_reg};
    assign out_stage.valid = c_valid_reg;
    assign out_stage.start = c_start_reg;
    assign out_stage.ovf   = c_ovf_reg;
    assign out_stage.rem   = c_rem_reg;
    assign out_stage.quo   = '0;

endmodule

/* design/csp_div_stage.sv */
module csp_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        en,
    input  csp_pkg::csp_div_t in_stage,
    output logic [1:0]        stage_valid,
    output csp_pkg::csp_div_t out_stage
);

    logic                      d_valid_reg;
    logic                      d_start_reg;
    logic                      d_ovf_reg;
    logic [31:0]               d_plo_reg;
    logic [csp_pkg::QUO_W-1:0] d_qest_reg;
    logic                      e_valid_reg;
    logic                      e_start_reg;
    logic                      e_ovf_reg;
    logic [31:0]               e_plo_reg;
    logic [31:0]               e_back_reg;
    logic [csp_pkg::QUO_W-1:0] e_qest_reg;
    logic                      f_valid_reg;
    logic                      f_start_reg;
    logic                      f_ovf_reg;
    logic [csp_pkg::QUO_W-1:0] f_quo_reg;
    logic [61:0]               recip_prod;
    logic [csp_pkg::QUO_W-1:0] qest_next;
    logic [31:0]               back_next;
    logic [31:0]               rem_lo;
    logic [csp_pkg::QUO_W-1:0] quo_next;

    // The estimate comes from the upper product bits only, so it never
    // exceeds the true quotient and falls short of it by at most two.
    assign recip_prod = {31'd0, in_stage.rem[csp_pkg::REM_W-1:30]} * {30'd0, csp_pkg::RECIP};
    assign qest_next  = recip_prod[61:31];

    // The remainder left by the estimate stays below three billion, so the
    // low 32 bits of the product and of the back-multiply are enough.
    assign back_next = {1'b0, d_qest_reg} * {2'd0, csp_pkg::NS_PER_SEC};
    assign rem_lo    = e_plo_reg - e_back_reg;

    always_comb
    begin
        if (rem_lo >= csp_pkg::NS_PER_TWO_SEC)
        begin
            quo_next = e_qest_reg + 31'd2;
        end
        else if (rem_lo >= {2'd0, csp_pkg::NS_PER_SEC})
        begin
            quo_next = e_qest_reg + 31'd1;
        end
        else
        begin
            quo_next = e_qest_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                d_valid_reg <= in_stage.valid;
            end
            if (en[1])
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (en[2])
            begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_start_reg <= in_stage.start;
            d_ovf_reg   <= in_stage.ovf;
            d_plo_reg   <= in_stage.rem[31:0];
            d_qest_reg  <= qest_next;
        end
        if (en[1])
        begin
            e_start_reg <= d_start_reg;
            e_ovf_reg   <= d_ovf_reg;
            e_plo_reg   <= d_plo_reg;
            e_back_reg  <= back_next;
            e_qest_reg  <= d_qest_reg;
        end
        if (en[2])
        begin
            f_start_reg <= e_start_reg;
            f_ovf_reg   <= e_ovf_reg;
            f_quo_reg   <= quo_next;
        end
    end

    assign stage_valid     = {e_valid_reg, d_valid_reg};
    assign out_stage.valid = f_valid_reg;
    assign out_stage.start = f_start_reg;
    assign out_stage.ovf   = f_ovf_reg;
    assign out_stage.rem   = '0;
    assign out_stage.quo   = f_quo_reg;

endmodule

/* design/csp_track.sv */
module csp_track (
    input  logic              clk,
    input  logic              rst_n,
    input  csp_pkg::csp_div_t in_stage,
    input  logic [30:0]       total_sends,
    input  logic              m_tready,
    output logic              en,
    output logic              m_tvalid,
    output logic [30:0]       burst,
    output logic [31:0]       first_seq,
    output logic [30:0]       largest_burst,
    output logic              done_res
);

    logic        out_valid_reg;
    logic [30:0] burst_reg;
    logic [31:0] first_seq_reg;
    logic [30:0] largest_reg;
    logic        done_reg;
    logic [30:0] sent_count_reg;
    logic [30:0] max_burst_reg;
    logic [31:0] seq_number_reg;
    logic        running_reg;

    logic        take;
    logic        run_cur;
    logic [30:0] sent_cur;
    logic [30:0] max_cur;
    logic [31:0] seq_cur;
    logic [31:0] target_raw;
    logic [30:0] target;
    logic [30:0] burst_next;
    logic [30:0] sent_count_next;
    logic [30:0] max_burst_next;
    logic [31:0] seq_number_next;
    logic        running_next;
    logic        done_next;

    assign en   = !out_valid_reg || m_tready;
    assign take = en && in_stage.valid;

    always_comb
    begin
        // A start beat evaluates against a freshly cleared run.
        run_cur  = in_stage.start || running_reg;
        sent_cur = in_stage.start ? 31'd0 : sent_count_reg;
        max_cur  = in_stage.start ? 31'd0 : max_burst_reg;
        seq_cur  = in_stage.start ? 32'd0 : seq_number_reg;

        target_raw = in_stage.ovf ? 32'h8000_0000 : {1'b0, in_stage.quo} + 32'd1;
        target     = (target_raw > {1'b0, total_sends}) ? total_sends : target_raw[30:0];

        if (run_cur && (target > sent_cur))
        begin
            burst_next = target - sent_cur;
        end
        else
        begin
            burst_next = 31'd0;
        end

        max_burst_next  = (burst_next > max_cur) ? burst_next : max_cur;
        seq_number_next = seq_cur + {1'b0, burst_next};
        sent_count_next = sent_cur + burst_next;
        running_next    = run_cur && !(sent_count_next >= total_sends);
        done_next       = !running_next && (sent_count_next >= total_sends);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            sent_count_reg <= 31'd0;
            max_burst_reg  <= 31'd0;
            seq_number_reg <= 32'd0;
            running_reg    <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                out_valid_reg <= in_stage.valid;
            end
            if (take)
            begin
                sent_count_reg <= sent_count_next;
                max_burst_reg  <= max_burst_next;
                seq_number_reg <= seq_number_next;
                running_reg    <= running_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            burst_reg     <= burst_next;
            first_seq_reg <= seq_cur;
            largest_reg   <= max_burst_next;
            done_reg      <= done_next;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign burst         = burst_reg;
    assign first_seq     = first_seq_reg;
    assign largest_burst = largest_reg;
    assign done_res      = done_reg;

endmodule
